/* design/baro_trim_compensation_macros.svh */
// Assertion macros for the barometer trim compensation block.
// Included by the top level; no other dependencies.
`ifndef BARO_TRIM_COMPENSATION_MACROS_SVH
`define BARO_TRIM_COMPENSATION_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define BTC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("btc check failed");
// Next-cycle implication.
`define BTC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("btc check failed");
`else
`define BTC_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define BTC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* design/btc_pkg.sv */
// Shared types and constants for the barometer trim compensation block.
// No dependencies; used by btc_wide_mul and baro_trim_compensation.
`default_nettype none

package btc_pkg;

   localparam int TEMP_FRAC_BITS_DEF  = 16;
   localparam int PRESS_FRAC_BITS_DEF = 6;

   // wide multiplier: operand A is cut into unsigned limbs, B is signed
   localparam int LIMB_W  = 24;
   localparam int MUL_B_W = 25;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 48;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMP_TRIM    = 8'd0,
      CSR_PRESS_TRIM_A = 8'd1,
      CSR_PRESS_TRIM_B = 8'd2,
      CSR_PRESS_TRIM_C = 8'd3
   } csr_index_type;

endpackage

`default_nettype wire

/* design/baro_trim_compensation.sv */
// Barometer trim compensation: raw pressure/temperature to compensated values.
// Depends on btc_pkg, btc_wide_mul and baro_trim_compensation_macros.svh.
//
//   channel   handshake               payload
//   request   start, busy             req_raw_pressure, req_raw_temperature, req_*_ready
//   result    rsp_strobe              rsp_sample_valid, rsp_temperature_out,
//                                     rsp_pressure_out, rsp_saturated
//   csr       csr_valid, csr_ready    csr_index, csr_wdata
//
// One sample is accepted every cycle; busy stays low.
// The result is on the result ports after the temperature stages followed by four chained
// two-stage wide multipliers (Horner in t, then up) and the output register.
// Reset is synchronous, clears the pipeline valid bits and the trim registers.
// The receiver cannot stall; nothing in the pipeline ever holds.
`default_nettype none

`include "baro_trim_compensation_macros.svh"

module baro_trim_compensation import btc_pkg::*; #(
   parameter int TEMP_FRAC_BITS  = TEMP_FRAC_BITS_DEF,
   parameter int PRESS_FRAC_BITS = PRESS_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [23:0]           req_raw_pressure,
   input  logic [23:0]           req_raw_temperature,
   input  logic                  req_pressure_ready,
   input  logic                  req_temperature_ready,
   output logic                  rsp_strobe,
   output logic                  rsp_sample_valid,
   output logic signed [23:0]    rsp_temperature_out,
   output logic [22:0]           rsp_pressure_out,
   output logic                  rsp_saturated,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int F       = TEMP_FRAC_BITS;
   localparam int PW      = 3 * F + 120;
   localparam int NUM_W   = 62;
   localparam int TS      = 48 - F;
   localparam int P_SHIFT = 65 + 3 * F - PRESS_FRAC_BITS;
   localparam int LAST    = 14;

   localparam logic signed [NUM_W-1:0] T_HI = 62'sd8388607;
   localparam logic signed [NUM_W-1:0] T_LO = -62'sd8388608;

   // trim registers
   logic [39:0] temp_trim_ff;
   logic [47:0] press_a_ff;
   logic [47:0] press_b_ff;
   logic [31:0] press_c_ff;

   logic [15:0]        t1, t2, p5, p6;
   logic signed [7:0]  t3, p3, p4, p7, p8, p10, p11;
   logic signed [15:0] p9;
   logic signed [16:0] p1m, p2m;

   // pipeline
   logic                    v_ff  [0:LAST];
   logic                    ok_ff [0:13];
   logic [23:0]             up_ff [0:11];
   logic [23:0]             ut0_ff;
   logic signed [25:0]      d1_in, d1_ff;
   logic signed [43:0]      dt2_in, dt2_ff;
   logic signed [51:0]      dd2_in, dd2_ff;
   logic signed [NUM_W-1:0] num3_in, num3_ff, tsh;
   logic signed [23:0]      t4_in;
   logic                    tsat4_in;
   logic signed [23:0]      t_ff    [4:13];
   logic                    tsat_ff [4:13];
   logic signed [31:0]      tp4, tp8, tp10;
   logic signed [32:0]      upp11_in, upp11_ff;
   logic [PW-1:0]           a1_in, b1_in, c1_in, a1_ff, b1_ff, c1_ff;
   logic [PW-1:0]           x6_in;
   logic [PW-1:0]           x_ff  [6:9];
   logic [PW-1:0]           a3_ff [10:11];
   logic [PW-1:0]           a2, b2, a3, b3, y11, z13;

   logic                    neg, big;
   logic [22:0]             pq_in;
   logic                    sample_valid_ff, sat_ff;
   logic signed [23:0]      temp_out_ff;
   logic [22:0]             press_out_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   assign t1  = temp_trim_ff[15:0];
   assign t2  = temp_trim_ff[31:16];
   assign t3  = temp_trim_ff[39:32];
   assign p1m = $signed({press_a_ff[15], press_a_ff[15:0]}) - 17'sd16384;
   assign p2m = $signed({press_a_ff[31], press_a_ff[31:16]}) - 17'sd16384;
   assign p3  = press_a_ff[39:32];
   assign p4  = press_a_ff[47:40];
   assign p5  = press_b_ff[15:0];
   assign p6  = press_b_ff[31:16];
   assign p7  = press_b_ff[39:32];
   assign p8  = press_b_ff[47:40];
   assign p9  = press_c_ff[15:0];
   assign p10 = press_c_ff[23:16];
   assign p11 = press_c_ff[31:24];

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_trim_ff <= '0;
         press_a_ff   <= '0;
         press_b_ff   <= '0;
         press_c_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_TEMP_TRIM:    temp_trim_ff <= csr_wdata[39:0];
            CSR_PRESS_TRIM_A: press_a_ff   <= csr_wdata;
            CSR_PRESS_TRIM_B: press_b_ff   <= csr_wdata;
            CSR_PRESS_TRIM_C: press_c_ff   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // temperature: d, products, sum, floor shift and clamp
   always_comb begin
      d1_in   = $signed({2'b00, ut0_ff}) - $signed({2'b00, t1, 8'h00});
      dt2_in  = 44'(d1_ff) * 44'($signed({1'b0, t2}));
      dd2_in  = 52'(d1_ff) * 52'(d1_ff);
      num3_in = (NUM_W'(dt2_ff) <<< 18) + NUM_W'(dd2_ff) * NUM_W'(t3);
      tsh     = num3_ff >>> TS;
      if (tsh > T_HI) begin
         t4_in    = T_HI[23:0];
         tsat4_in = 1'b1;
      end else if (tsh < T_LO) begin
         t4_in    = T_LO[23:0];
         tsat4_in = 1'b1;
      end else begin
         t4_in    = tsh[23:0];
         tsat4_in = 1'b0;
      end
   end

   // innermost Horner coefficients in t, and the up^3 term
   always_comb begin
      tp4      = 32'(t_ff[4]) * 32'(p4);
      tp8      = 32'(t_ff[4]) * 32'(p8);
      tp10     = 32'(t_ff[4]) * 32'(p10);
      upp11_in = 33'($signed({1'b0, up_ff[4]})) * 33'(p11);
      a1_in    = (PW'(p7) << (7 + F)) + PW'(tp8);
      b1_in    = (PW'(p3) << (5 + F)) + PW'(tp4);
      c1_in    = (PW'(p9) << F) + PW'(tp10);
      x6_in    = (c1_ff << (17 + 2 * F)) + (PW'(upp11_ff) << (3 * F));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAST; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         v_ff[0] <= start && !busy;
         for (int k = 1; k <= LAST; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      ok_ff[0] <= req_pressure_ready && req_temperature_ready;
      for (int k = 1; k <= 13; k++) begin
         ok_ff[k] <= ok_ff[k-1];
      end
      up_ff[0] <= req_raw_pressure;
      for (int k = 1; k <= 11; k++) begin
         up_ff[k] <= up_ff[k-1];
      end
      ut0_ff     <= req_raw_temperature;
      d1_ff      <= d1_in;
      dt2_ff     <= dt2_in;
      dd2_ff     <= dd2_in;
      num3_ff    <= num3_in;
      t_ff[4]    <= t4_in;
      tsat_ff[4] <= tsat4_in;
      for (int k = 5; k <= 13; k++) begin
         t_ff[k]    <= t_ff[k-1];
         tsat_ff[k] <= tsat_ff[k-1];
      end
      a1_ff    <= a1_in;
      b1_ff    <= b1_in;
      c1_ff    <= c1_in;
      upp11_ff <= upp11_in;
      x_ff[6]  <= x6_in;
      for (int k = 7; k <= 9; k++) begin
         x_ff[k] <= x_ff[k-1];
      end
      a3_ff[10] <= a3;
      a3_ff[11] <= a3_ff[10];
   end

   btc_wide_mul #(.PW(PW)) u_mul_a2 (
      .clock (clock),
      .a     (a1_ff),
      .b     (MUL_B_W'(t_ff[5])),
      .c     (PW'(p6) << (9 + 2 * F)),
      .p     (a2)
   );

   btc_wide_mul #(.PW(PW)) u_mul_b2 (
      .clock (clock),
      .a     (b1_ff),
      .b     (MUL_B_W'(t_ff[5])),
      .c     (PW'(p2m) << (8 + 2 * F)),
      .p     (b2)
   );

   btc_wide_mul #(.PW(PW)) u_mul_a3 (
      .clock (clock),
      .a     (a2),
      .b     (MUL_B_W'(t_ff[7])),
      .c     (PW'(p5) << (18 + 3 * F)),
      .p     (a3)
   );

   btc_wide_mul #(.PW(PW)) u_mul_b3 (
      .clock (clock),
      .a     (b2),
      .b     (MUL_B_W'(t_ff[7])),
      .c     (PW'(p1m) << (17 + 3 * F)),
      .p     (b3)
   );

   // Horner in up: y = B + up*x, z = A + up*y
   btc_wide_mul #(.PW(PW)) u_mul_y (
      .clock (clock),
      .a     (x_ff[9]),
      .b     (MUL_B_W'({1'b0, up_ff[9]})),
      .c     (b3 << 28),
      .p     (y11)
   );

   btc_wide_mul #(.PW(PW)) u_mul_z (
      .clock (clock),
      .a     (y11),
      .b     (MUL_B_W'({1'b0, up_ff[11]})),
      .c     (a3_ff[11] << 50),
      .p     (z13)
   );

   // pressure floor shift and clamp
   always_comb begin
      neg = z13[PW-1];
      big = |z13[PW-1:P_SHIFT+23];
      if (neg) begin
         pq_in = '0;
      end else if (big) begin
         pq_in = '1;
      end else begin
         pq_in = z13[P_SHIFT+22:P_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (ok_ff[13]) begin
         sample_valid_ff <= 1'b1;
         temp_out_ff     <= t_ff[13];
         press_out_ff    <= pq_in;
         sat_ff          <= tsat_ff[13] || neg || big;
      end else begin
         sample_valid_ff <= 1'b0;
         temp_out_ff     <= '0;
         press_out_ff    <= '0;
         sat_ff          <= 1'b0;
      end
   end

   assign rsp_strobe          = v_ff[LAST];
   assign rsp_sample_valid    = sample_valid_ff;
   assign rsp_temperature_out = temp_out_ff;
   assign rsp_pressure_out    = press_out_ff;
   assign rsp_saturated       = sat_ff;

   `BTC_ASSERT_NEXT(a_fixed_latency, clock, reset, start && !busy, ##(LAST) rsp_strobe)
   `BTC_ASSERT_SAME(a_not_ready_zero, clock, reset, rsp_strobe && !rsp_sample_valid,
                    rsp_temperature_out == 0 && rsp_pressure_out == 0 && !rsp_saturated)

endmodule

`default_nettype wire

/* design/btc_wide_mul.sv */
// Two-stage wide multiply-add modulo 2^PW: p = a * b + c, b signed.
// Depends on btc_pkg for the limb and B-operand widths.
`default_nettype none

module btc_wide_mul import btc_pkg::*; #(
   parameter int PW = 168
) (
   input  logic                      clock,
   input  logic [PW-1:0]             a,
   input  logic signed [MUL_B_W-1:0] b,
   input  logic [PW-1:0]             c,
   output logic [PW-1:0]             p
);

   localparam int NL   = (PW + LIMB_W - 1) / LIMB_W;
   localparam int AW   = NL * LIMB_W;
   localparam int PP_W = LIMB_W + 1 + MUL_B_W;

   logic [AW-1:0]           a_ext;
   logic signed [PP_W-1:0]  pp_in [NL];
   logic signed [PP_W-1:0]  pp_ff [NL];
   logic [PW-1:0]           c_ff;
   logic [PW-1:0]           sum_in;
   logic [PW-1:0]           p_ff;

   // one partial product per limb
   always_comb begin
      a_ext = AW'(a);
      for (int k = 0; k < NL; k++) begin
         pp_in[k] = PP_W'($signed({1'b0, a_ext[k*LIMB_W +: LIMB_W]})) * PP_W'(b);
      end
   end

   always_comb begin
      sum_in = c_ff;
      for (int k = 0; k < NL; k++) begin
         sum_in = sum_in + (PW'(pp_ff[k]) << (k * LIMB_W));
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NL; k++) begin
         pp_ff[k] <= pp_in[k];
      end
      c_ff <= c;
      p_ff <= sum_in;
   end

   assign p = p_ff;

endmodule

`default_nettype wire

/* verif/baro_trim_compensation_test.sv */
// Self-checking testbench for baro_trim_compensation: trim writes, directed and random samples.
// Depends on btc_pkg and the baro_trim_compensation RTL; the expected values come from an
// exact wide-integer evaluation of the trim polynomial.
`timescale 1ns / 100ps

module baro_trim_compensation_test import btc_pkg::*;;

   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_UNUSED = 8'd200;
   localparam int PIPE_DEPTH = 15;

   typedef struct packed {
      logic               sample_valid;
      logic signed [23:0] temperature;
      logic [22:0]        pressure;
      logic               saturated;
   } baro_reading_type;

   class baro_scoreboard_type;
      logic [39:0] temp_trim;
      logic [47:0] press_trim_a, press_trim_b;
      logic [31:0] press_trim_c;
      baro_reading_type pending_readings[$];
      int errors;

      function new();
         temp_trim = '0; press_trim_a = '0; press_trim_b = '0; press_trim_c = '0;
         errors = 0;
      endfunction

      function void write_trim(logic [CSR_IDX_W-1:0] idx, logic [47:0] data);
         unique case (idx)
            CSR_TEMP_TRIM:    temp_trim    = data[39:0];
            CSR_PRESS_TRIM_A: press_trim_a = data;
            CSR_PRESS_TRIM_B: press_trim_b = data;
            CSR_PRESS_TRIM_C: press_trim_c = data[31:0];
            default: ;
         endcase
      endfunction

      function logic signed [255:0] poly_term(logic signed [255:0] coef, logic signed [255:0] up,
                                              int nu, logic signed [255:0] t, int nt, int shift);
         logic signed [255:0] v;
         v = coef;
         repeat (nu) v = v * up;
         repeat (nt) v = v * t;
         return v <<< shift;
      endfunction

      function baro_reading_type compensate(logic [23:0] up, logic [23:0] ut, logic pr, logic tr);
         baro_reading_type r;
         logic signed [127:0] d, num, tq, t1, t2, t3;
         logic signed [255:0] acc, uv, tv, c, sh;
         r = '0;
         if (!(pr && tr)) return r;
         t1 = $signed({112'b0, temp_trim[15:0]});
         t2 = $signed({112'b0, temp_trim[31:16]});
         t3 = $signed(temp_trim[39:32]);
         d = $signed({104'b0, ut}) - t1 * 256;
         num = d * t2 * 262144 + d * d * t3;
         tq = num >>> 32;
         if (tq > 8388607) begin
            tq = 8388607; r.saturated = 1;
         end
         if (tq < -8388608) begin
            tq = -8388608; r.saturated = 1;
         end
         r.temperature = tq[23:0];
         uv = $signed({232'b0, up});
         tv = tq;
         acc = '0;
         c = $signed({240'b0, press_trim_b[15:0]});    acc += poly_term(c, uv, 0, tv, 0, 116);
         c = $signed({240'b0, press_trim_b[31:16]});   acc += poly_term(c, uv, 0, tv, 1, 91);
         c = $signed(press_trim_b[39:32]);             acc += poly_term(c, uv, 0, tv, 2, 73);
         c = $signed(press_trim_b[47:40]);             acc += poly_term(c, uv, 0, tv, 3, 50);
         c = $signed(press_trim_a[15:0]);  c -= 16384; acc += poly_term(c, uv, 1, tv, 0, 93);
         c = $signed(press_trim_a[31:16]); c -= 16384; acc += poly_term(c, uv, 1, tv, 1, 68);
         c = $signed(press_trim_a[39:32]);             acc += poly_term(c, uv, 1, tv, 2, 49);
         c = $signed(press_trim_a[47:40]);             acc += poly_term(c, uv, 1, tv, 3, 28);
         c = $signed(press_trim_c[15:0]);              acc += poly_term(c, uv, 2, tv, 0, 65);
         c = $signed(press_trim_c[23:16]);             acc += poly_term(c, uv, 2, tv, 1, 49);
         c = $signed(press_trim_c[31:24]);             acc += poly_term(c, uv, 3, tv, 0, 48);
         if (acc < 0) begin
            r.pressure = '0; r.saturated = 1;
         end else begin
            sh = acc >>> 107;
            if (sh > 256'sh7FFFFF) begin
               r.pressure = 23'h7FFFFF; r.saturated = 1;
            end else
               r.pressure = sh[22:0];
         end
         r.sample_valid = 1;
         return r;
      endfunction

      function void note_sample(logic [23:0] up, logic [23:0] ut, logic pr, logic tr);
         pending_readings.push_back(compensate(up, ut, pr, tr));
      endfunction

      function void check_reading(baro_reading_type got);
         baro_reading_type exp_r;
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
            return;
         end
         exp_r = pending_readings.pop_front();
         if (got.sample_valid !== exp_r.sample_valid) begin
            $display("%0t: sample_valid expected %0d actual %0d",
                     $time, exp_r.sample_valid, got.sample_valid);
            errors++;
         end
         if (got.temperature !== exp_r.temperature) begin
            $display("%0t: temperature expected %0d actual %0d",
                     $time, exp_r.temperature, got.temperature);
            errors++;
         end
         if (got.pressure !== exp_r.pressure) begin
            $display("%0t: pressure expected %0d actual %0d",
                     $time, exp_r.pressure, got.pressure);
            errors++;
         end
         if (got.saturated !== exp_r.saturated) begin
            $display("%0t: saturated expected %0d actual %0d",
                     $time, exp_r.saturated, got.saturated);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1, start = 0;
   logic busy;
   logic [23:0] req_raw_pressure = '0, req_raw_temperature = '0;
   logic req_pressure_ready = 0, req_temperature_ready = 0;
   logic rsp_strobe, rsp_sample_valid, rsp_saturated;
   logic signed [23:0] rsp_temperature_out;
   logic [22:0] rsp_pressure_out;
   logic csr_valid = 0, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   baro_scoreboard_type readings = new();
   int idle_pct;

   baro_trim_compensation DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("baro_trim_compensation_test: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         readings.check_reading({rsp_sample_valid, rsp_temperature_out,
                                 rsp_pressure_out, rsp_saturated});
   end

   task automatic write_trim(logic [CSR_IDX_W-1:0] idx, logic [47:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      readings.write_trim(idx, data);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic send_sample(logic [23:0] up, logic [23:0] ut, logic pr, logic tr);
      // idle each cycle with the phase's probability
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_raw_pressure <= up;
      req_raw_temperature <= ut;
      req_pressure_ready <= pr;
      req_temperature_ready <= tr;
      do @(posedge clock); while (busy);
      readings.note_sample(up, ut, pr, tr);
   endtask

   // hold off until the pipeline is empty
   task automatic drain();
      start <= 0;
      while (readings.pending_readings.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 5) @(posedge clock);
   endtask

   task automatic load_trims(int kind);
      logic [47:0] v[4];
      unique case (kind)
         0: v = '{48'h0, 48'h0, 48'h0, 48'h0};
         1: v = '{48'hFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF};
         2: v = '{48'({8'hF9, 16'd26000, 16'd27500}), {8'd12, 8'hF0, 16'hFC00, 16'd5000},
                  {8'hF8, 8'd30, 16'd30000, 16'd20000}, 48'({8'hFF, 8'd2, 16'd16000})};
         default: begin
            v[0] = 48'({8'($urandom_range(255)), 16'($urandom_range(15000, 30000)),
                        16'($urandom_range(20000, 30000))});
            v[1] = 48'({$urandom(), $urandom()});
            v[2] = 48'({$urandom(), $urandom()});
            v[3] = 48'($urandom());
            if (kind == 3) begin
               v[0] = 48'({$urandom(), $urandom()});
               v[1] = {16'(v[1][47:32] & 16'h0F0F), v[1][31:0]};
            end
         end
      endcase
      write_trim(CSR_TEMP_TRIM, v[0]);
      write_trim(CSR_PRESS_TRIM_A, v[1]);
      write_trim(CSR_PRESS_TRIM_B, v[2]);
      write_trim(CSR_PRESS_TRIM_C, v[3]);
   endtask

   initial begin
      logic [23:0] up, ut;
      int idle_plan[6] = '{0, 71, 32, 0, 71, 32};
      int offset;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      idle_pct = 0;

      // trims at reset value, then the not-ready cases
      send_sample(24'h0, 24'h0, 1, 1);
      send_sample(24'hFFFFFF, 24'hFFFFFF, 1, 1);
      send_sample(24'h123456, 24'h654321, 0, 1);
      send_sample(24'h123456, 24'h654321, 1, 0);
      send_sample(24'hFFFFFF, 24'hFFFFFF, 0, 0);
      drain();
      write_trim(CSR_INDEX_UNUSED, 48'hFFFF_FFFF_FFFF);
      for (int k = 1; k <= 2; k++) begin
         load_trims(k);
         send_sample(24'h0, 24'h0, 1, 1);
         send_sample(24'hFFFFFF, 24'h0, 1, 1);
         send_sample(24'h0, 24'hFFFFFF, 1, 1);
         send_sample(24'hFFFFFF, 24'hFFFFFF, 1, 1);
         send_sample(24'd6_500_000, 24'd7_040_000, 1, 1);
         send_sample(24'd8_600_000, 24'd8_200_000, 1, 1);
         send_sample(24'd4_000_000, 24'd6_000_000, 1, 1);
         send_sample(24'h800000, 24'h800000, 0, 1);
         drain();
      end

      for (int ph = 0; ph < 6; ph++) begin
         load_trims(2 + ph % 3);
         idle_pct = idle_plan[ph];
         repeat (195) begin
            up = 24'($urandom());
            ut = 24'($urandom());
            if ($urandom_range(99) < 70) begin
               // keep temperature near the calibration point for mostly unclamped results
               offset = int'($urandom_range(0, 2 * 400000)) - 400000;
               ut = 24'(int'(readings.temp_trim[15:0]) * 256 + offset);
               up = 24'($urandom_range(2_000_000, 12_000_000));
            end
            send_sample(up, ut, $urandom_range(99) < 90, $urandom_range(99) < 90);
         end
         drain();
      end
      idle_pct = 0;
      load_trims(0);
      send_sample(24'hABCDEF, 24'h123456, 1, 1);
      drain();

      if (readings.errors == 0)
         $display("baro_trim_compensation_test: done, clean");
      else
         $display("baro_trim_compensation_test: done, errors");
      $finish;
   end

endmodule
